FILE: sv/dfsq_pkg.sv
// ----------------------------------------------------------------------------
// dfsq_pkg
// Shared types and constants of the display frame stability qualifier.
// ----------------------------------------------------------------------------
package dfsq_pkg;

	localparam int BYTE_W  = 8;
	localparam int SEG_W   = 7;
	localparam int COUNT_W = 8;
	localparam int POS_W   = 6;
	localparam int CODE_W  = 2;
	localparam int INDEX_W = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;
	localparam logic [POS_W-1:0]   POS_MAX   = 6'd63;

	// Status codes.
	localparam logic [CODE_W-1:0] ST_DISCARD = 2'd0;
	localparam logic [CODE_W-1:0] ST_NEW     = 2'd1;
	localparam logic [CODE_W-1:0] ST_REPEAT  = 2'd2;
	localparam logic [CODE_W-1:0] ST_REACHED = 2'd3;

	// Result kinds.
	localparam logic KIND_STATUS  = 1'b0;
	localparam logic KIND_DISPLAY = 1'b1;

	// Register indexes.
	localparam logic REG_MIN_REPEATS = 1'b0;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] repeat_count;
		logic [COUNT_W-1:0] flash_count;
	} eval_t;

endpackage

FILE: sv/dfsq_frame_track.sv
// ----------------------------------------------------------------------------
// dfsq_frame_track
// Packet buffer, stored frame and counters; evaluates a finished packet.
// ----------------------------------------------------------------------------
module dfsq_frame_track #(
	parameter int PACKET_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dfsq_pkg::COUNT_W-1:0]  min_repeats,
	input  logic                          wr_en,
	input  logic [dfsq_pkg::BYTE_W-1:0]   wr_data,
	input  logic                          wr_last,
	output logic                          len_ok,
	input  logic                          eval_go,
	input  logic                          eval_len_ok,
	output dfsq_pkg::eval_t               eval,
	output logic [dfsq_pkg::COUNT_W-1:0]  repeat_cnt,
	output logic [dfsq_pkg::COUNT_W-1:0]  flash_cnt,
	input  logic [$clog2(PACKET_BYTES)-1:0] rd_pos,
	output logic [dfsq_pkg::SEG_W-1:0]    rd_seg
);

	localparam int IW = $clog2(PACKET_BYTES);
	localparam logic [dfsq_pkg::POS_W-1:0] PB     = dfsq_pkg::POS_W'(PACKET_BYTES);
	localparam logic [dfsq_pkg::POS_W-1:0] PB_END = dfsq_pkg::POS_W'(PACKET_BYTES - 1);

	logic [dfsq_pkg::BYTE_W-1:0]  frame_q  [PACKET_BYTES];
	logic [dfsq_pkg::BYTE_W-1:0]  buffer_q [PACKET_BYTES];
	logic [dfsq_pkg::POS_W-1:0]   pos_q;
	logic [dfsq_pkg::COUNT_W-1:0] repeat_q;
	logic [dfsq_pkg::COUNT_W-1:0] flash_q;
	logic                         masked_change;
	logic                         decimal_change;
	logic [dfsq_pkg::COUNT_W-1:0] repeat_inc;
	logic [dfsq_pkg::COUNT_W-1:0] flash_inc;

	assign len_ok     = (pos_q == PB_END);
	assign repeat_cnt = repeat_q;
	assign flash_cnt  = flash_q;
	assign rd_seg     = frame_q[rd_pos][dfsq_pkg::SEG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (wr_en) begin
			if (wr_last) begin
				pos_q <= '0;
			end else if (pos_q != dfsq_pkg::POS_MAX) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Bytes past the packet size are dropped.
	always_ff @(posedge clk) begin
		if (wr_en && pos_q < PB) begin
			buffer_q[pos_q[IW-1:0]] <= wr_data;
		end
	end

	// The buffer is complete when the evaluation runs, so the whole packet is
	// compared against the frame at once.
	always_comb begin
		masked_change = 1'b0;
		for (int i = 0; i < PACKET_BYTES; i++) begin
			if (buffer_q[i][dfsq_pkg::SEG_W-1:0] != frame_q[i][dfsq_pkg::SEG_W-1:0]) begin
				masked_change = 1'b1;
			end
		end
	end

	assign decimal_change = (buffer_q[2] != frame_q[2]);
	assign repeat_inc = (repeat_q != dfsq_pkg::COUNT_MAX) ? repeat_q + 1'b1 : repeat_q;
	assign flash_inc  = (decimal_change && flash_q != dfsq_pkg::COUNT_MAX) ?
		flash_q + 1'b1 : flash_q;

	always_comb begin
		priority if (!eval_len_ok) begin
			eval.code         = dfsq_pkg::ST_DISCARD;
			eval.repeat_count = repeat_q;
			eval.flash_count  = flash_q;
		end else if (masked_change) begin
			eval.code         = dfsq_pkg::ST_NEW;
			eval.repeat_count = '0;
			eval.flash_count  = dfsq_pkg::COUNT_W'(buffer_q[2][dfsq_pkg::BYTE_W-1]);
		end else begin
			eval.code         = (repeat_inc == min_repeats) ?
				dfsq_pkg::ST_REACHED : dfsq_pkg::ST_REPEAT;
			eval.repeat_count = repeat_inc;
			eval.flash_count  = flash_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= '0;
			flash_q  <= '0;
			for (int i = 0; i < PACKET_BYTES; i++) begin
				frame_q[i] <= '0;
			end
		end else if (eval_go) begin
			repeat_q <= eval.repeat_count;
			flash_q  <= eval.flash_count;
			if (eval.code == dfsq_pkg::ST_NEW) begin
				for (int i = 0; i < PACKET_BYTES; i++) begin
					frame_q[i] <= buffer_q[i];
				end
			end
		end
	end

endmodule

FILE: sv/display_frame_stability_qualifier_core.sv
// ----------------------------------------------------------------------------
// display_frame_stability_qualifier_core
// Qualifies received display packets and emits the frame once it is stable.
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle unless a held packet end stalls
// it. Every byte that ends a packet gives one status transaction, held in
// end_v_s1 and then the output register; when a repeat brings the repeat
// count to min_repeats, PACKET_BYTES-2 display byte transactions follow it,
// one per cycle unless m_tready stalls, out of the single output register.
// Bytes that do not end a packet are always taken while the output drains;
// the next packet end waits in the evaluation register until the display
// run has gone out, blocking new bytes meanwhile. Reset needs no clearing pass.
module display_frame_stability_qualifier_core #(
	parameter int PACKET_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [1:0] status_code, [9:2] repeat_count,
	                               // [17:10] flash_count, [22:18] digit_index,
	                               // [29:23] digit_segments, [31:30] zero
	output logic        m_tuser,   // result_kind
	output logic        m_tlast,   // run_end
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = $clog2(PACKET_BYTES);
	localparam logic [dfsq_pkg::INDEX_W-1:0] RUN_LAST =
		dfsq_pkg::INDEX_W'(PACKET_BYTES - 3);

	logic [dfsq_pkg::COUNT_W-1:0] min_repeats_q;
	logic                         end_v_s1;
	logic                         len_ok_s1;
	logic                         in_acc;
	logic                         out_free;
	logic                         eval_go;
	logic                         len_ok;
	dfsq_pkg::eval_t              eval;
	logic [dfsq_pkg::COUNT_W-1:0] repeat_cnt;
	logic [dfsq_pkg::COUNT_W-1:0] flash_cnt;
	logic [IW-1:0]                rd_pos;
	logic [dfsq_pkg::SEG_W-1:0]   rd_seg;

	logic                          run_q;
	logic [dfsq_pkg::INDEX_W-1:0]  run_idx_q;
	logic                          out_v_q;
	logic                          out_kind_q;
	logic [dfsq_pkg::CODE_W-1:0]   out_code_q;
	logic [dfsq_pkg::COUNT_W-1:0]  out_repeat_q;
	logic [dfsq_pkg::COUNT_W-1:0]  out_flash_q;
	logic [dfsq_pkg::INDEX_W-1:0]  out_idx_q;
	logic [dfsq_pkg::SEG_W-1:0]    out_seg_q;
	logic                          out_end_q;

	// Configuration.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == dfsq_pkg::REG_MIN_REPEATS) ? 32'(min_repeats_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_repeats_q <= 8'd3;
		end else if (psel && penable && pwrite && paddr[2] == dfsq_pkg::REG_MIN_REPEATS) begin
			min_repeats_q <= pwdata[dfsq_pkg::COUNT_W-1:0];
		end
	end

	// Handshakes. A held packet end blocks new bytes, since the next packet
	// would overwrite the buffer before it is compared.
	assign out_free = !out_v_q || m_tready;
	assign eval_go  = end_v_s1 && !run_q && out_free;
	assign s_tready = !end_v_s1 || eval_go;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_v_s1 <= 1'b0;
		end else if (in_acc && s_tlast) begin
			end_v_s1 <= 1'b1;
		end else if (eval_go) begin
			end_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			len_ok_s1 <= len_ok;
		end
	end

	dfsq_frame_track #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.min_repeats (min_repeats_q),
		.wr_en       (in_acc),
		.wr_data     (s_tdata),
		.wr_last     (s_tlast),
		.len_ok      (len_ok),
		.eval_go     (eval_go),
		.eval_len_ok (len_ok_s1),
		.eval        (eval),
		.repeat_cnt  (repeat_cnt),
		.flash_cnt   (flash_cnt),
		.rd_pos      (rd_pos),
		.rd_seg      (rd_seg)
	);

	// Display bytes start at packet byte two.
	assign rd_pos = IW'(6'(run_idx_q) + 6'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q   <= 1'b0;
			run_q     <= 1'b0;
			run_idx_q <= '0;
		end else if (out_free) begin
			if (run_q) begin
				out_v_q   <= 1'b1;
				run_idx_q <= run_idx_q + 1'b1;
				if (run_idx_q == RUN_LAST) begin
					run_q <= 1'b0;
				end
			end else if (eval_go) begin
				out_v_q   <= 1'b1;
				run_idx_q <= '0;
				run_q     <= (eval.code == dfsq_pkg::ST_REACHED);
			end else begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (run_q) begin
				out_kind_q   <= dfsq_pkg::KIND_DISPLAY;
				out_code_q   <= dfsq_pkg::ST_REACHED;
				out_repeat_q <= repeat_cnt;
				out_flash_q  <= flash_cnt;
				out_idx_q    <= run_idx_q;
				out_seg_q    <= rd_seg;
				out_end_q    <= (run_idx_q == RUN_LAST);
			end else if (eval_go) begin
				out_kind_q   <= dfsq_pkg::KIND_STATUS;
				out_code_q   <= eval.code;
				out_repeat_q <= eval.repeat_count;
				out_flash_q  <= eval.flash_count;
				out_idx_q    <= '0;
				out_seg_q    <= '0;
				out_end_q    <= (eval.code != dfsq_pkg::ST_REACHED);
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_end_q;
	assign m_tdata  = {2'b00, out_seg_q, out_idx_q, out_flash_q, out_repeat_q, out_code_q};

endmodule
